FILE: sv/tga_pkg.sv
// Shared types and constants for the TGA run-length packet decoder.
`default_nettype none
package tga_pkg;

  localparam int unsigned MAX_PIXELS          = 1048576;
  localparam int unsigned MAX_BYTES_PER_PIXEL = 4;
  localparam int unsigned RAW_HEADER_MAX      = 127;

  localparam int unsigned BPP_W   = 3;
  localparam int unsigned TOTAL_W = 21;
  localparam int unsigned INDEX_W = 20;
  localparam int unsigned RUN_W   = 8;
  localparam int unsigned PIXEL_W = 32;
  localparam int unsigned CFG_W   = 21;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 64;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  // Configuration register indexes.
  localparam logic CFG_BYTES_PER_PIXEL = 1'b0;
  localparam logic CFG_TOTAL_PIXELS    = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HEADER = 2'd1,
    PH_PIXEL  = 2'd2,
    PH_STOP   = 2'd3
  } phase_t;

  // One classified stream byte as it waits between front and back.
  typedef struct packed {
    logic [7:0]       stream_byte;
    logic             start;
    logic             repeat_hdr;
    logic [RUN_W-1:0] hdr_count;
  } queue_entry_t;

endpackage
`default_nettype wire

FILE: sv/tga_front.sv
// Front end: accepts stream bytes, classifies them as headers and queues them.
`default_nettype none
module tga_front
  import tga_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [7:0]   in_byte,
  input  wire logic         in_start,
  output logic              q_valid,
  output queue_entry_t      q_entry,
  input  wire logic         q_pop
);

  queue_entry_t           mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]      fill_r, fill_nxt;
  logic                   push;
  logic                   pop;
  queue_entry_t           new_entry;

  // The header interpretation is worked out here so the back end only
  // has to pick it up when the byte really is a header.
  always_comb begin
    new_entry.stream_byte = in_byte;
    new_entry.start       = in_start;
    if (in_byte <= 8'(RAW_HEADER_MAX)) begin
      new_entry.repeat_hdr = 1'b0;
      new_entry.hdr_count  = in_byte + 8'd1;
    end else begin
      new_entry.repeat_hdr = 1'b1;
      new_entry.hdr_count  = in_byte - 8'(RAW_HEADER_MAX);
    end
  end

  assign in_ready = (fill_r != QCNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (fill_r != '0);
  assign pop      = q_pop && q_valid;
  assign q_entry  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt   = fill_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= new_entry;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue fill count beyond depth");

  a_ptr_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r == '0 || fill_r == QCNT_W'(QUEUE_DEPTH)) |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers disagree with fill count");

endmodule
`default_nettype wire

FILE: sv/tga_back.sv
// Back end: packet state machine, pixel assembly and the result register.
`default_nettype none
module tga_back
  import tga_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_wdata,
  input  wire logic               q_valid,
  input  wire queue_entry_t       q_entry,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [PIXEL_W-1:0]      out_pixel,
  output logic [RUN_W-1:0]        out_run,
  output logic [INDEX_W-1:0]      out_index,
  output logic                    out_done,
  output logic                    out_status
);

  logic [BPP_W-1:0]   bpp_r;
  logic [TOTAL_W-1:0] total_r;

  phase_t             phase_r, phase_nxt;
  logic [RUN_W-1:0]   left_r, left_nxt;
  logic               rep_r, rep_nxt;
  logic [1:0]         bip_r, bip_nxt;
  logic [PIXEL_W-1:0] asm_r, asm_nxt;
  logic [TOTAL_W-1:0] pd_r, pd_nxt;

  logic               ovalid_r, ovalid_nxt;
  logic [PIXEL_W-1:0] opix_r;
  logic [RUN_W-1:0]   orun_r;
  logic [INDEX_W-1:0] oidx_r;
  logic               odone_r;
  logic               ostat_r;

  logic [BPP_W-1:0]   eff_bpp;
  logic [TOTAL_W-1:0] eff_total;

  phase_t             ph_cur;
  logic [RUN_W-1:0]   left_cur;
  logic               rep_cur;
  logic [1:0]         bip_cur;
  logic [PIXEL_W-1:0] asm_cur;
  logic [TOTAL_W-1:0] pd_cur;
  logic [PIXEL_W-1:0] asm_add;
  logic [TOTAL_W:0]   hdr_sum;
  logic [RUN_W-1:0]   run;
  logic [TOTAL_W-1:0] pd_sum;

  logic               res_valid;
  logic [PIXEL_W-1:0] res_pixel;
  logic [RUN_W-1:0]   res_run;
  logic [INDEX_W-1:0] res_index;
  logic               res_done;
  logic               res_status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r   <= BPP_W'(MAX_BYTES_PER_PIXEL);
      total_r <= TOTAL_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BYTES_PER_PIXEL: bpp_r   <= cfg_wdata[BPP_W-1:0];
        CFG_TOTAL_PIXELS:    total_r <= cfg_wdata[TOTAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (bpp_r == '0) begin
      eff_bpp = BPP_W'(1);
    end else if (bpp_r > BPP_W'(MAX_BYTES_PER_PIXEL)) begin
      eff_bpp = BPP_W'(MAX_BYTES_PER_PIXEL);
    end else begin
      eff_bpp = bpp_r;
    end
    eff_total = (total_r > TOTAL_W'(MAX_PIXELS)) ? TOTAL_W'(MAX_PIXELS) : total_r;
  end

  // A request is taken whenever the result register is free or draining.
  assign q_pop = q_valid && (!ovalid_r || out_ready);

  always_comb begin
    ph_cur   = q_entry.start ? PH_HEADER : phase_r;
    left_cur = q_entry.start ? '0 : left_r;
    rep_cur  = q_entry.start ? 1'b0 : rep_r;
    bip_cur  = q_entry.start ? '0 : bip_r;
    asm_cur  = q_entry.start ? '0 : asm_r;
    pd_cur   = q_entry.start ? '0 : pd_r;

    case (bip_cur)
      2'd0:    asm_add = {24'd0, q_entry.stream_byte};
      2'd1:    asm_add = {16'd0, q_entry.stream_byte, 8'd0};
      2'd2:    asm_add = {8'd0, q_entry.stream_byte, 16'd0};
      default: asm_add = {q_entry.stream_byte, 24'd0};
    endcase

    hdr_sum = (TOTAL_W+1)'(q_entry.hdr_count) + (TOTAL_W+1)'(pd_cur);
    run     = rep_cur ? left_cur : RUN_W'(1);
    pd_sum  = pd_cur + TOTAL_W'(run);

    phase_nxt  = ph_cur;
    left_nxt   = left_cur;
    rep_nxt    = rep_cur;
    bip_nxt    = bip_cur;
    asm_nxt    = asm_cur;
    pd_nxt     = pd_cur;
    res_valid  = 1'b0;
    res_pixel  = '0;
    res_run    = q_entry.hdr_count;
    res_index  = pd_cur[INDEX_W-1:0];
    res_done   = 1'b0;
    res_status = 1'b0;

    case (ph_cur)
      PH_HEADER: begin
        if (hdr_sum > (TOTAL_W+1)'(eff_total)) begin
          phase_nxt  = PH_STOP;
          res_valid  = 1'b1;
          res_status = 1'b1;
        end else begin
          left_nxt  = q_entry.hdr_count;
          rep_nxt   = q_entry.repeat_hdr;
          bip_nxt   = '0;
          asm_nxt   = '0;
          phase_nxt = PH_PIXEL;
        end
      end
      PH_PIXEL: begin
        if (BPP_W'(bip_cur) + BPP_W'(1) < eff_bpp) begin
          bip_nxt = bip_cur + 2'd1;
          asm_nxt = asm_cur | asm_add;
        end else begin
          res_valid = 1'b1;
          res_pixel = asm_cur | asm_add;
          res_run   = run;
          res_done  = (pd_sum >= eff_total);
          left_nxt  = rep_cur ? '0 : left_cur - RUN_W'(1);
          pd_nxt    = pd_sum;
          bip_nxt   = '0;
          asm_nxt   = '0;
          if (res_done) begin
            phase_nxt = PH_STOP;
          end else if (left_nxt == '0) begin
            phase_nxt = PH_HEADER;
          end
        end
      end
      default: ;
    endcase

    if (q_pop && res_valid) begin
      ovalid_nxt = 1'b1;
    end else if (out_ready) begin
      ovalid_nxt = 1'b0;
    end else begin
      ovalid_nxt = ovalid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      left_r   <= '0;
      rep_r    <= 1'b0;
      bip_r    <= '0;
      asm_r    <= '0;
      pd_r     <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        phase_r <= phase_nxt;
        left_r  <= left_nxt;
        rep_r   <= rep_nxt;
        bip_r   <= bip_nxt;
        asm_r   <= asm_nxt;
        pd_r    <= pd_nxt;
      end
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && res_valid) begin
      opix_r  <= res_pixel;
      orun_r  <= res_run;
      oidx_r  <= res_index;
      odone_r <= res_done;
      ostat_r <= res_status;
    end
  end

  assign out_valid  = ovalid_r;
  assign out_pixel  = opix_r;
  assign out_run    = orun_r;
  assign out_index  = oidx_r;
  assign out_done   = odone_r;
  assign out_status = ostat_r;

  a_stop_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && res_valid && (res_status || res_done)) |=> phase_r == PH_STOP)
    else $error("decoder kept running after overrun or image end");

  a_done_not_error: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> !(odone_r && ostat_r))
    else $error("result flagged both done and overrun");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pd_r <= TOTAL_W'(MAX_PIXELS))
    else $error("decoded pixel count beyond the largest image");

  a_no_pop_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !out_ready) |-> !q_pop)
    else $error("request taken while the result register is stalled");

endmodule
`default_nettype wire

FILE: sv/tga_rle_packet_decoder.sv
// Top level of the TGA run-length packet decoder.
//
//  channel  direction  handshake            payload
//  in_      slave      in_tvalid/in_tready  tdata: stream_byte; tuser: start_of_image
//  out_     master     out_tvalid/out_tready tdata: pixel, run, index; tlast: image_done;
//                                            tuser: status
//  cfg_     write      cfg_we               cfg_index, cfg_wdata
//
// One byte is decoded per cycle while the decoder is not stalled; a byte is decoded into the result
// register when the decoder pops it from the queue, and its result is then offered on out_.
// A four-entry queue separates the input from the decoder; it absorbs up to four bytes
// while a result waits, and the decoder stalls only while the result register is full
// and out_tready is low.
// Reset is synchronous and active low; it empties the queue and idles the decoder.
`default_nettype none
module tga_rle_packet_decoder
  import tga_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] stream_byte
  input  wire logic                  in_tuser,   // [0] start_of_image
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [31:0] pixel_value, [39:32] run_count, [59:40] first_pixel_index, [63:60] zero
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic                       out_tlast,  // image_done
  output logic                       out_tuser,  // [0] status
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_wdata
);

  logic               q_valid;
  logic               q_pop;
  queue_entry_t       q_entry;
  logic [PIXEL_W-1:0] pixel;
  logic [RUN_W-1:0]   run;
  logic [INDEX_W-1:0] index;

  tga_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_byte  (in_tdata),
    .in_start (in_tuser),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .q_pop    (q_pop)
  );

  tga_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .q_pop      (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_pixel  (pixel),
    .out_run    (run),
    .out_index  (index),
    .out_done   (out_tlast),
    .out_status (out_tuser)
  );

  assign out_tdata = {4'd0, index, run, pixel};

endmodule
`default_nettype wire

FILE: tb/tb_tga_rle_packet_decoder.sv
// Self-checking testbench for the TGA run-length packet decoder: directed and random streams.
`default_nettype none
module tb_tga_rle_packet_decoder;
  import tga_pkg::*;

  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned SETTLE_TICKS = 8;
  localparam int unsigned RANDOM_ITEMS = 1300;

  typedef struct packed {
    logic [7:0] data;
    logic       sop;
  } stream_item_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic [RUN_W-1:0]   run;
    logic [INDEX_W-1:0] index;
    logic               done;
    logic               status;
  } pixel_run_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  out_tuser;
  logic                  cfg_we = 1'b0;
  logic                  cfg_index = CFG_BYTES_PER_PIXEL;
  logic [CFG_W-1:0]      cfg_wdata = '0;

  tga_rle_packet_decoder i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Decoder shadow: configuration and packet state as the block should hold them.
  logic [BPP_W-1:0]   shadow_bpp   = 3'd4;
  logic [TOTAL_W-1:0] shadow_total = 21'd1;
  phase_t             dec_phase    = PH_IDLE;
  logic [RUN_W-1:0]   px_left      = '0;
  logic               rep_pkt      = 1'b0;
  logic [1:0]         byte_pos     = '0;
  logic [PIXEL_W-1:0] px_acc       = '0;
  int unsigned        px_count     = 0;

  stream_item_t byte_queue[$];
  pixel_run_t   pending_runs[$];
  int unsigned  items_queued   = 0;
  int unsigned  items_accepted = 0;
  int unsigned  mismatches     = 0;
  int unsigned  send_idle_pct  = 29;
  int unsigned  recv_idle_pct  = 29;
  int unsigned  quiet_cycles   = 0;

  function automatic int unsigned eff_bpp(logic [BPP_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > MAX_BYTES_PER_PIXEL) return MAX_BYTES_PER_PIXEL;
    return 32'(raw);
  endfunction

  function automatic int unsigned eff_total(logic [TOTAL_W-1:0] raw);
    return (raw > MAX_PIXELS) ? MAX_PIXELS : 32'(raw);
  endfunction

  // Advances the shadow by one stream byte; returns 1 when a run comes out.
  function automatic bit decode_byte(logic [7:0] b, logic sop, output pixel_run_t run_out);
    int unsigned count;
    logic        rep_hdr;
    run_out = '0;
    if (sop) begin
      dec_phase = PH_HEADER;
      px_left   = '0;
      rep_pkt   = 1'b0;
      byte_pos  = '0;
      px_acc    = '0;
      px_count  = 0;
    end
    if (dec_phase == PH_HEADER) begin
      if (b <= RAW_HEADER_MAX) begin
        count   = b + 1;
        rep_hdr = 1'b0;
      end else begin
        count   = b - RAW_HEADER_MAX;
        rep_hdr = 1'b1;
      end
      if (count + px_count > eff_total(shadow_total)) begin
        dec_phase      = PH_STOP;
        run_out.run    = RUN_W'(count);
        run_out.index  = INDEX_W'(px_count);
        run_out.status = 1'b1;
        return 1'b1;
      end
      px_left   = RUN_W'(count);
      rep_pkt   = rep_hdr;
      byte_pos  = '0;
      px_acc    = '0;
      dec_phase = PH_PIXEL;
      return 1'b0;
    end
    if (dec_phase == PH_PIXEL) begin
      px_acc = px_acc | (PIXEL_W'(b) << (8 * byte_pos));
      if (int'(byte_pos) + 1 < eff_bpp(shadow_bpp)) begin
        byte_pos = byte_pos + 2'd1;
        return 1'b0;
      end
      run_out.pixel = px_acc;
      run_out.index = INDEX_W'(px_count);
      if (rep_pkt) begin
        run_out.run = px_left;
        px_left     = '0;
      end else begin
        run_out.run = 8'd1;
        px_left     = px_left - 8'd1;
      end
      px_count     = px_count + run_out.run;
      byte_pos     = '0;
      px_acc       = '0;
      run_out.done = (px_count >= eff_total(shadow_total));
      if (run_out.done)
        dec_phase = PH_STOP;
      else if (px_left == 0)
        dec_phase = PH_HEADER;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH @%0t: %s", $time, what);
    mismatches++;
  endtask

  // Input side: one request stays on the bus until it is taken.
  always @(posedge clk) begin
    stream_item_t nxt;
    pixel_run_t   run_exp;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        items_accepted++;
        if (decode_byte(in_tdata, in_tuser, run_exp))
          pending_runs.push_back(run_exp);
      end
      if (!in_tvalid || in_tready) begin
        if (byte_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = byte_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= nxt.data;
          in_tuser  <= nxt.sop;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result side: random back-pressure and comparison against the oldest expected run.
  always @(posedge clk) begin
    pixel_run_t run_exp;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_runs.size() == 0) begin
          report_mismatch($sformatf("unexpected result data=%h last=%b user=%b",
                                    out_tdata, out_tlast, out_tuser));
        end else begin
          run_exp = pending_runs.pop_front();
          if (out_tdata[31:0] !== run_exp.pixel || out_tdata[39:32] !== run_exp.run ||
              out_tdata[59:40] !== run_exp.index || out_tdata[63:60] !== 4'd0 ||
              out_tlast !== run_exp.done || out_tuser !== run_exp.status)
            report_mismatch($sformatf(
              "got %h %0d %0d pad=%h %b %b, want px=%h run=%0d idx=%0d done=%b st=%b",
              out_tdata[31:0], out_tdata[39:32], out_tdata[59:40], out_tdata[63:60],
              out_tlast, out_tuser, run_exp.pixel, run_exp.run, run_exp.index,
              run_exp.done, run_exp.status));
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic push_byte(logic [7:0] b, logic sop);
    byte_queue.push_back('{data: b, sop: sop});
    items_queued++;
  endtask

  task automatic wait_drained();
    while (items_accepted != items_queued || pending_runs.size() != 0)
      @(posedge clk);
    // Bytes that give no result may still be inside the block.
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_BYTES_PER_PIXEL)
      shadow_bpp = val[BPP_W-1:0];
    else
      shadow_total = val[TOTAL_W-1:0];
  endtask

  // Well-formed packets covering npix pixels, optionally cut short after max_bytes.
  task automatic queue_image(int unsigned npix, int unsigned bpp, int unsigned max_bytes);
    int unsigned left_px;
    int unsigned count;
    int unsigned sent;
    bit          rep;
    left_px = npix;
    sent    = 0;
    while (left_px > 0 && sent < max_bytes) begin
      count = $urandom_range(1, (left_px < 128) ? left_px : 128);
      rep   = 1'($urandom_range(1));
      push_byte(rep ? 8'(count + RAW_HEADER_MAX) : 8'(count - 1), sent == 0);
      sent++;
      repeat (rep ? bpp : count * bpp) begin
        if (sent < max_bytes) begin
          push_byte(8'($urandom_range(255)), 1'b0);
          sent++;
        end
      end
      left_px -= count;
    end
  endtask

  initial begin
    int unsigned random_base;
    int unsigned tot;
    int unsigned npix;
    int unsigned phase_no;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset configuration: four bytes per pixel, a one-pixel image.
    push_byte(8'hAB, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'h01, 1'b0);
    push_byte(8'h02, 1'b0);
    push_byte(8'h03, 1'b0);
    push_byte(8'h04, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h12, 1'b0);
    wait_drained();

    // Restart inside a raw packet, a repeat packet, then a pixel left half built.
    write_reg(CFG_BYTES_PER_PIXEL, 21'd3);
    write_reg(CFG_TOTAL_PIXELS, 21'd300);
    push_byte(8'h7F, 1'b1);
    repeat (3) push_byte(8'hFF, 1'b0);
    push_byte(8'h80, 1'b1);
    repeat (3) push_byte(8'h00, 1'b0);
    push_byte(8'h85, 1'b0);
    push_byte(8'h5A, 1'b0);
    push_byte(8'hA5, 1'b0);
    push_byte(8'h3C, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h11, 1'b0);
    push_byte(8'h22, 1'b0);
    wait_drained();
    // Fewer bytes per pixel now: the next byte finishes the pixel.
    write_reg(CFG_BYTES_PER_PIXEL, 21'd1);
    push_byte(8'hC3, 1'b0);
    push_byte(8'h5A, 1'b0);
    wait_drained();
    write_reg(CFG_TOTAL_PIXELS, 21'd0);
    push_byte(8'h00, 1'b1);
    wait_drained();

    random_base = items_queued;
    phase_no    = 0;
    while (items_queued - random_base < RANDOM_ITEMS) begin
      phase_no++;
      send_idle_pct = (phase_no == 3) ? 0 : 29;
      recv_idle_pct = (phase_no == 3) ? 0 : 29;
      write_reg(CFG_BYTES_PER_PIXEL, CFG_W'($urandom_range(7)));
      case ($urandom_range(9))
        0:       tot = 0;
        1:       tot = 1;
        2:       tot = $urandom_range(MAX_PIXELS - 5, 2 ** TOTAL_W - 1);
        default: tot = $urandom_range(2, 60);
      endcase
      write_reg(CFG_TOTAL_PIXELS, CFG_W'(tot));
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(9) == 0) begin
          repeat ($urandom_range(1, 8))
            push_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
        end else begin
          tot  = eff_total(shadow_total);
          npix = (tot > 60) ? $urandom_range(1, 60) :
                 ($urandom_range(3) == 0) ? $urandom_range(1, tot + 3) : ((tot == 0) ? 1 : tot);
          queue_image(npix, eff_bpp(shadow_bpp),
                      ($urandom_range(5) == 0) ? $urandom_range(1, 12) : 32'hFFFF_FFFF);
          if ($urandom_range(3) == 0)
            push_byte(8'($urandom_range(255)), 1'b0);
        end
      end
      // Sender holds off until every outstanding run has been returned.
      wait_drained();
    end

    // Saturated total, zero bytes per pixel acting as one, long packets, no idling.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CFG_BYTES_PER_PIXEL, 21'd0);
    write_reg(CFG_TOTAL_PIXELS, 21'h1FFFFF);
    for (int i = 0; i < 64; i++) begin
      push_byte(8'hFF, i == 0);
      push_byte(8'($urandom_range(255)), 1'b0);
    end
    push_byte(8'h7E, 1'b0);
    repeat (127) push_byte(8'($urandom_range(255)), 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'($urandom_range(255)), 1'b0);
    push_byte(8'h77, 1'b0);
    wait_drained();

    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
`default_nettype wire

FILE: tga_rle_packet_decoder.f
sv/tga_pkg.sv
sv/tga_front.sv
sv/tga_back.sv
sv/tga_rle_packet_decoder.sv
tb/tb_tga_rle_packet_decoder.sv
